>>> sv/strace_pkg.sv
`timescale 1ns / 1ps

package strace_pkg;

  localparam int unsigned SEQ_W    = 64;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned REQ_W    = 7;

  localparam logic KIND_RECORD   = 1'b0;
  localparam logic KIND_SNAPSHOT = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [PHASE_W-1:0] phase;
    logic [WORD_W-1:0]  detail;
    logic [WORD_W-1:0]  timestamp;
    logic [REQ_W-1:0]   max_entries;
  } in_item_t;

  typedef struct packed {
    logic               entry_valid;
    logic [SEQ_W-1:0]   seq_number;
    logic [WORD_W-1:0]  stamp;
    logic [WORD_W-1:0]  detail_out;
    logic [PHASE_W-1:0] phase_out;
    logic               last;
  } out_item_t;

  // one read issue toward the output stage
  typedef struct packed {
    logic             valid;
    logic             entry_valid;
    logic             last;
    logic [SEQ_W-1:0] seq;
  } issue_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } ctrl_state_t;

endpackage

>>> sv/strace_mem.sv
`timescale 1ns / 1ps

module strace_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 160
) (
  input  logic                          clk,
  input  strace_pkg::mem_ctrl_t         ctrl,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [DATA_W-1:0]             wr_data,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [DATA_W-1:0]             rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/strace_ctrl.sv
`timescale 1ns / 1ps

module strace_ctrl #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         kind,
  input  logic [strace_pkg::REQ_W-1:0] max_entries,
  output logic                         busy,
  output strace_pkg::mem_ctrl_t        mem_ctrl,
  output logic [$clog2(DEPTH)-1:0]     wr_addr,
  output logic [$clog2(DEPTH)-1:0]     rd_addr,
  output strace_pkg::issue_t           issue
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = $clog2(2 * DEPTH + 1);
  localparam int unsigned SEQ_W = strace_pkg::SEQ_W;
  localparam int unsigned REQ_W = strace_pkg::REQ_W;

  strace_pkg::ctrl_state_t state_r, state_nxt;

  logic [SEQ_W-1:0] latest_r, latest_nxt;
  logic [IDX_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [IDX_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;

  logic             do_record;
  logic             do_snap;
  logic [CNT_W-1:0] held;
  logic [REQ_W-1:0] req_cnt;
  logic [CNT_W-1:0] snap_cnt;
  logic [SUM_W-1:0] start_sum;
  logic [IDX_W-1:0] start_slot;
  logic [SEQ_W-1:0] oldest;
  logic [SEQ_W-1:0] rec_seq;
  logic [IDX_W-1:0] rec_slot;
  logic             last_issue;

  assign do_record = accept && (kind == strace_pkg::KIND_RECORD);
  assign do_snap   = accept && (kind == strace_pkg::KIND_SNAPSHOT);

  // record: next sequence and its slot; slot wraps at the ring end and restarts at zero when sequence wraps
  assign rec_seq = latest_r + SEQ_W'(1);
  always_comb begin
    if (rec_seq == '0) begin
      rec_slot = '0;
    end else if (wr_slot_r == IDX_W'(DEPTH - 1)) begin
      rec_slot = '0;
    end else begin
      rec_slot = wr_slot_r + IDX_W'(1);
    end
  end

  // snapshot window
  assign held     = (latest_r < SEQ_W'(DEPTH)) ? CNT_W'(latest_r) : CNT_W'(DEPTH);
  assign req_cnt  = (max_entries < REQ_W'(held)) ? max_entries : REQ_W'(held);
  assign snap_cnt = CNT_W'(req_cnt);
  assign oldest   = latest_r - SEQ_W'(held) + SEQ_W'(1);
  assign start_sum = SUM_W'(wr_slot_r) + SUM_W'(DEPTH + 1) - SUM_W'(held);
  assign start_slot = (start_sum >= SUM_W'(DEPTH)) ? IDX_W'(start_sum - SUM_W'(DEPTH))
                                                   : IDX_W'(start_sum);

  assign last_issue = (remain_r == CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      strace_pkg::ST_IDLE: begin
        if (do_snap && (snap_cnt != '0)) begin
          state_nxt = strace_pkg::ST_READ;
        end
      end
      strace_pkg::ST_READ: begin
        if (last_issue) begin
          state_nxt = strace_pkg::ST_IDLE;
        end
      end
      default: state_nxt = strace_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    latest_nxt  = latest_r;
    wr_slot_nxt = wr_slot_r;
    rd_slot_nxt = rd_slot_r;
    remain_nxt  = remain_r;
    seq_nxt     = seq_r;
    mem_ctrl    = '0;
    issue       = '0;
    busy        = 1'b0;
    unique case (state_r)
      strace_pkg::ST_IDLE: begin
        if (do_record) begin
          latest_nxt     = rec_seq;
          wr_slot_nxt    = rec_slot;
          mem_ctrl.wr_en = 1'b1;
        end else if (do_snap) begin
          if (snap_cnt == '0) begin
            issue.valid = 1'b1;
            issue.last  = 1'b1;
          end else begin
            rd_slot_nxt = start_slot;
            remain_nxt  = snap_cnt;
            seq_nxt     = oldest;
          end
        end
      end
      strace_pkg::ST_READ: begin
        busy              = 1'b1;
        mem_ctrl.rd_en    = 1'b1;
        issue.valid       = 1'b1;
        issue.entry_valid = 1'b1;
        issue.last        = last_issue;
        issue.seq         = seq_r;
        rd_slot_nxt = (rd_slot_r == IDX_W'(DEPTH - 1)) ? '0 : rd_slot_r + IDX_W'(1);
        remain_nxt  = remain_r - CNT_W'(1);
        seq_nxt     = seq_r + SEQ_W'(1);
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  assign wr_addr = rec_slot;
  assign rd_addr = rd_slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= strace_pkg::ST_IDLE;
      latest_r  <= '0;
      wr_slot_r <= '0;
      remain_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      latest_r  <= latest_nxt;
      wr_slot_r <= wr_slot_nxt;
      remain_r  <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r <= rd_slot_nxt;
    seq_r     <= seq_nxt;
  end

  a_read_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == strace_pkg::ST_READ) |-> (remain_r != '0))
    else $error("read pass running with no entries left");

  a_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == strace_pkg::ST_READ) && last_issue) |=> (state_r == strace_pkg::ST_IDLE))
    else $error("read pass did not stop after its final entry");

  a_record_bumps: assert property (@(posedge clk) disable iff (!rst_n)
    do_record && (state_r == strace_pkg::ST_IDLE) |=> (latest_r == $past(latest_r) + SEQ_W'(1)))
    else $error("record beat did not advance the sequence");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_slot_r <= IDX_W'(DEPTH - 1)) && (rd_slot_r <= IDX_W'(DEPTH - 1) ||
     state_r == strace_pkg::ST_IDLE))
    else $error("slot pointer beyond ring depth");

endmodule

>>> sv/sequenced_trace_ring_core.sv
`timescale 1ns / 1ps
// Trace ring keeping the last DEPTH markers in one synchronous memory.
// Input channel: in_item is taken at a rising edge with start high and busy
// low. A record beat (kind = record) stores phase, detail and timestamp at
// the slot of the next sequence number and gives no result; records may
// arrive every cycle while busy is low.
// A snapshot beat returns the oldest min(max_entries, held) markers, oldest
// first, with their sequence numbers; the final one carries last. A zero
// request or an empty ring gives one result with entry_valid low and last.
// Result channel: out_strobe marks a result for exactly one cycle; the
// receiver always takes it and cannot stall the block.
// A snapshot keeps busy high while it reads; the accepted beat is registered
// into the read state, each read into the memory and issue tag registers,
// and results come one per cycle, paced by the single memory read port.
// A zero or empty snapshot keeps busy low; its result shows the next cycle.
// Reset (rst_n low, synchronous) clears the sequence counter, so the ring
// reads as empty; the memory contents are not cleared and need no sweep.
module sequenced_trace_ring_core #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned PHASE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  strace_pkg::in_item_t  in_item,
  output logic                  out_strobe,
  output strace_pkg::out_item_t out_item
);

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  // phase is truncated to PHASE_BITS, and never wider than the port
  localparam int unsigned PH_W   = (PHASE_BITS < strace_pkg::PHASE_W) ?
                                   PHASE_BITS : strace_pkg::PHASE_W;
  localparam int unsigned WORD_W = strace_pkg::WORD_W;
  localparam int unsigned DATA_W = 2 * WORD_W + PH_W;

  logic                  accept;
  strace_pkg::mem_ctrl_t mem_ctrl;
  logic [IDX_W-1:0]      wr_addr;
  logic [IDX_W-1:0]      rd_addr;
  logic [DATA_W-1:0]     wr_data;
  logic [DATA_W-1:0]     rd_data;
  strace_pkg::issue_t    issue;
  strace_pkg::issue_t    pend_r;

  logic [WORD_W-1:0]     rd_stamp;
  logic [WORD_W-1:0]     rd_detail;
  logic [PH_W-1:0]       rd_phase;

  assign accept = start && !busy;

  // pack the stored beat: stamp, detail, phase
  assign wr_data = {in_item.timestamp, in_item.detail, in_item.phase[PH_W-1:0]};

  strace_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .kind        (in_item.kind),
    .max_entries (in_item.max_entries),
    .busy        (busy),
    .mem_ctrl    (mem_ctrl),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .issue       (issue)
  );

  strace_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk     (clk),
    .ctrl    (mem_ctrl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // register the issue tag so it lines up with the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r.valid <= 1'b0;
    end else begin
      pend_r.valid <= issue.valid;
    end
    pend_r.entry_valid <= issue.entry_valid;
    pend_r.last        <= issue.last;
    pend_r.seq         <= issue.seq;
  end

  assign rd_stamp  = rd_data[DATA_W-1 -: WORD_W];
  assign rd_detail = rd_data[PH_W +: WORD_W];
  assign rd_phase  = rd_data[PH_W-1:0];

  // drop payload to zero on the no-marker result
  always_comb begin
    out_item.entry_valid = pend_r.entry_valid;
    out_item.last        = pend_r.last;
    if (pend_r.entry_valid) begin
      out_item.seq_number = pend_r.seq;
      out_item.stamp      = rd_stamp;
      out_item.detail_out = rd_detail;
      out_item.phase_out  = strace_pkg::PHASE_W'(rd_phase);
    end else begin
      out_item.seq_number = '0;
      out_item.stamp      = '0;
      out_item.detail_out = '0;
      out_item.phase_out  = '0;
    end
  end

  assign out_strobe = pend_r.valid;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last) |=> !out_strobe || !busy)
    else $error("result beat after the final one of a snapshot");

  a_no_mem_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctrl.wr_en && mem_ctrl.rd_en))
    else $error("memory written while a read pass runs");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.entry_valid) |-> out_item.last)
    else $error("no-marker result not marked last");

endmodule
